>>> sv/adam_upd_pkg.sv
package adam_upd_pkg;

  localparam int unsigned PARAM_COUNT = 1024;
  localparam int unsigned IdxW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

  localparam int unsigned AddrW = 4;

  localparam logic [23:0] STEP_SIZE_RST    = 24'd16777;
  localparam logic [15:0] FIRST_DECAY_RST  = 16'd58982;
  localparam logic [15:0] SECOND_DECAY_RST = 16'd65470;
  localparam logic [31:0] STABILIZER_RST   = 32'd1;

  // Q1.32 one
  localparam logic [32:0] POW_ONE = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    REG_STEP_SIZE    = 2'd0,
    REG_FIRST_DECAY  = 2'd1,
    REG_SECOND_DECAY = 2'd2,
    REG_STABILIZER   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [23:0] step_size;
    logic [15:0] first_decay;
    logic [15:0] second_decay;
    logic [31:0] stabilizer;
  } cfg_t;

  // classified item: store address, gradient, bias-correction divisors
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [31:0]     grad;
    logic [32:0]     d1;
    logic [32:0]     d2;
  } item_t;

  // updated moments handed to the math pipeline
  typedef struct packed {
    logic        valid;
    logic [31:0] m;
    logic [63:0] v;
    logic [32:0] d1;
    logic [32:0] d2;
  } mom_t;

endpackage

>>> sv/adam_upd_ram.sv
module adam_upd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/adam_upd_front.sv
module adam_upd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [9:0]                param_index_i,
  input  logic [31:0]               gradient_i,
  input  logic                      first_of_batch_i,
  input  adam_upd_pkg::cfg_t        cfg_i,
  input  logic                      hold_i,
  input  logic                      pop_i,
  output logic                      head_valid_o,
  output adam_upd_pkg::item_t       head_o
);
  import adam_upd_pkg::*;

  logic [32:0] p1_q, p1_d, p2_q, p2_d;
  logic [48:0] p1_prod, p2_prod;
  logic [32:0] d1_raw, d2_raw;
  item_t       new_item;
  item_t       ent_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign in_ready_o = (cnt_q != 2'd2) && !hold_i;
  assign push       = in_valid_i && in_ready_o;

  // running powers advance before the item that opens a batch
  assign p1_prod = p1_q * cfg_i.first_decay;
  assign p2_prod = p2_q * cfg_i.second_decay;
  assign p1_d    = first_of_batch_i ? p1_prod[48:16] : p1_q;
  assign p2_d    = first_of_batch_i ? p2_prod[48:16] : p2_q;
  assign d1_raw  = POW_ONE - p1_d;
  assign d2_raw  = POW_ONE - p2_d;

  always_comb begin
    new_item.idx  = IdxW'({22'd0, param_index_i} % PARAM_COUNT);
    new_item.grad = gradient_i;
    // power still one: no correction
    new_item.d1   = (d1_raw == '0) ? POW_ONE : d1_raw;
    new_item.d2   = (d2_raw == '0) ? POW_ONE : d2_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q  <= POW_ONE;
      p2_q  <= POW_ONE;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        p1_q <= p1_d;
        p2_q <= p2_d;
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= new_item;
    end
  end

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent_q[rp_q];

endmodule

>>> sv/adam_upd_moment.sv
module adam_upd_moment (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  adam_upd_pkg::cfg_t        cfg_i,
  input  logic                      adv_i,
  input  logic                      head_valid_i,
  input  adam_upd_pkg::item_t       head_i,
  output logic                      pop_o,
  output logic                      clearing_o,
  output adam_upd_pkg::mom_t        mom_o
);
  import adam_upd_pkg::*;

  logic            clr_act_q;
  logic [IdxW-1:0] clr_addr_q;

  logic            s1_valid_q;
  item_t           s1_item_q;
  logic [63:0]     g2_q;
  logic [63:0]     gsq;

  logic            s2_valid_q;
  logic [IdxW-1:0] s2_idx_q;
  logic [31:0]     s2_m_q;
  logic [63:0]     s2_v_q;
  logic [32:0]     s2_d1_q, s2_d2_q;

  logic [95:0]     rdata;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [95:0]     wdata;
  logic            fwd;
  logic [31:0]     old_m;
  logic [63:0]     old_v;

  logic signed [17:0] b1s, c1s;
  logic signed [49:0] pm_a, pm_b;
  logic signed [50:0] msum;
  logic [31:0]        m_new;
  logic [16:0]        c1v, c2v;
  logic [48:0]        ph_a, ph_b, pl_a, pl_b;
  logic [49:0]        hsum, lsum;
  logic [63:0]        v_new;

  assign clearing_o = clr_act_q;
  assign pop_o      = adv_i && head_valid_i && !clr_act_q;

  // clearing pass, one entry per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q  <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_act_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == IdxW'(PARAM_COUNT - 1)) begin
        clr_act_q <= 1'b0;
      end
    end
  end

  assign gsq = 64'($signed(head_i.grad) * $signed(head_i.grad));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= pop_o;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_item_q <= head_i;
      g2_q      <= gsq;
      s2_idx_q  <= s1_item_q.idx;
      s2_m_q    <= m_new;
      s2_v_q    <= v_new;
      s2_d1_q   <= s1_item_q.d1;
      s2_d2_q   <= s1_item_q.d2;
    end
  end

  // previous item wrote at the same edge this one was read
  assign fwd   = s2_valid_q && (s2_idx_q == s1_item_q.idx);
  assign old_m = fwd ? s2_m_q : rdata[31:0];
  assign old_v = fwd ? s2_v_q : rdata[95:32];

  assign b1s  = {2'b00, cfg_i.first_decay};
  assign c1s  = 18'sd65536 - b1s;
  assign pm_a = b1s * $signed(old_m);
  assign pm_b = c1s * $signed(s1_item_q.grad);
  assign msum = 51'(pm_a) + 51'(pm_b);
  assign m_new = msum[47:16];

  assign c1v  = {1'b0, cfg_i.second_decay};
  assign c2v  = 17'h10000 - c1v;
  assign ph_a = c1v * old_v[63:32];
  assign ph_b = c2v * g2_q[63:32];
  assign pl_a = c1v * old_v[31:0];
  assign pl_b = c2v * g2_q[31:0];
  assign hsum = 50'(ph_a) + 50'(ph_b);
  assign lsum = 50'(pl_a) + 50'(pl_b);
  assign v_new = 64'({hsum, 16'd0}) + 64'(lsum[49:16]);

  assign we    = clr_act_q || (s1_valid_q && adv_i);
  assign waddr = clr_act_q ? clr_addr_q : s1_item_q.idx;
  assign wdata = clr_act_q ? '0 : {v_new, m_new};

  adam_upd_ram #(
    .Width (96),
    .Depth (PARAM_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (pop_o),
    .raddr_i (head_i.idx),
    .rdata_o (rdata)
  );

  always_comb begin
    mom_o.valid = s2_valid_q;
    mom_o.m     = s2_m_q;
    mom_o.v     = s2_v_q;
    mom_o.d1    = s2_d1_q;
    mom_o.d2    = s2_d2_q;
  end

endmodule

>>> sv/adam_upd_math.sv
module adam_upd_math (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adam_upd_pkg::cfg_t  cfg_i,
  input  logic                adv_i,
  input  adam_upd_pkg::mom_t  mom_i,
  output logic                res_valid_o,
  output logic [31:0]         update_o,
  output logic                saturated_o
);
  import adam_upd_pkg::*;

  localparam int unsigned DivSteps  = 64;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned QSteps    = 32;

  typedef struct packed {
    logic        neg;
    logic [32:0] d1;
    logic [32:0] d2;
    logic [63:0] a;
    logic [32:0] r1;
    logic [63:0] b;
    logic [32:0] r2;
    logic        vsat;
  } dv_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mh;
    logic [63:0] x;
    logic [33:0] r;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic        zero;
    logic [40:0] dv;
    logic [40:0] r;
    logic [31:0] a;
  } qd_t;

  // bias-correction dividers: |m|*2^32/d1 and v*2^32/d2
  dv_t  dv_in [DivSteps];
  dv_t  dv_nx [DivSteps];
  dv_t  dv_q  [DivSteps];
  logic dv_vi [DivSteps];
  logic dv_vq [DivSteps];
  dv_t  dv_entry;
  logic [31:0] mag;

  assign mag = mom_i.m[31] ? 32'(-mom_i.m) : mom_i.m;

  always_comb begin
    dv_entry.neg  = mom_i.m[31];
    dv_entry.d1   = mom_i.d1;
    dv_entry.d2   = mom_i.d2;
    dv_entry.a    = {mag, 32'd0};
    dv_entry.r1   = '0;
    dv_entry.vsat = ({1'b0, mom_i.v[63:32]} >= mom_i.d2);
    dv_entry.r2   = dv_entry.vsat ? '0 : {1'b0, mom_i.v[63:32]};
    dv_entry.b    = {mom_i.v[31:0], 32'd0};
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [33:0] t1, t2;
    logic        ge1, ge2;
    if (i == 0) begin : g_first
      assign dv_in[i] = dv_entry;
      assign dv_vi[i] = mom_i.valid;
    end else begin : g_next
      assign dv_in[i] = dv_q[i-1];
      assign dv_vi[i] = dv_vq[i-1];
    end
    assign t1  = {dv_in[i].r1, dv_in[i].a[63]};
    assign t2  = {dv_in[i].r2, dv_in[i].b[63]};
    assign ge1 = t1 >= {1'b0, dv_in[i].d1};
    assign ge2 = t2 >= {1'b0, dv_in[i].d2};
    always_comb begin
      dv_nx[i]    = dv_in[i];
      dv_nx[i].r1 = ge1 ? 33'(t1 - {1'b0, dv_in[i].d1}) : t1[32:0];
      dv_nx[i].a  = {dv_in[i].a[62:0], ge1};
      dv_nx[i].r2 = ge2 ? 33'(t2 - {1'b0, dv_in[i].d2}) : t2[32:0];
      dv_nx[i].b  = {dv_in[i].b[62:0], ge2};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vq[i] <= 1'b0;
      end else if (adv_i) begin
        dv_vq[i] <= dv_vi[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dv_q[i] <= dv_nx[i];
      end
    end
  end

  // integer square root, one root bit per stage
  sq_t  sq_in [SqrtSteps];
  sq_t  sq_nx [SqrtSteps];
  sq_t  sq_q  [SqrtSteps];
  logic sq_vi [SqrtSteps];
  logic sq_vq [SqrtSteps];
  sq_t  sq_entry;

  always_comb begin
    sq_entry.neg  = dv_q[DivSteps-1].neg;
    sq_entry.mh   = dv_q[DivSteps-1].a;
    sq_entry.x    = dv_q[DivSteps-1].vsat ? '1 : dv_q[DivSteps-1].b;
    sq_entry.r    = '0;
    sq_entry.root = '0;
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    logic [35:0] t, trial;
    logic        ge;
    if (i == 0) begin : g_first
      assign sq_in[i] = sq_entry;
      assign sq_vi[i] = dv_vq[DivSteps-1];
    end else begin : g_next
      assign sq_in[i] = sq_q[i-1];
      assign sq_vi[i] = sq_vq[i-1];
    end
    assign t     = {sq_in[i].r, sq_in[i].x[63:62]};
    assign trial = {2'b00, sq_in[i].root, 2'b01};
    assign ge    = t >= trial;
    always_comb begin
      sq_nx[i]      = sq_in[i];
      sq_nx[i].r    = ge ? 34'(t - trial) : t[33:0];
      sq_nx[i].root = {sq_in[i].root[30:0], ge};
      sq_nx[i].x    = {sq_in[i].x[61:0], 2'b00};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vq[i] <= 1'b0;
      end else if (adv_i) begin
        sq_vq[i] <= sq_vi[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sq_q[i] <= sq_nx[i];
      end
    end
  end

  // denominator and alpha * mhat halves
  logic        p_vq;
  logic        p_neg_q;
  logic [32:0] den_q;
  logic [55:0] ph_q, pl_q;

  // 88-bit product, overflow check, top of the dividend
  logic        q_vq;
  qd_t         q_entry_q;
  logic [87:0] prod;
  logic [40:0] dvs;
  logic        zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vq <= 1'b0;
      q_vq <= 1'b0;
    end else if (adv_i) begin
      p_vq <= sq_vq[SqrtSteps-1];
      q_vq <= p_vq;
    end
  end

  assign prod = {ph_q, 32'd0} + {32'd0, pl_q};
  assign dvs  = {den_q, 8'd0};
  assign zero = (den_q == '0);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_neg_q <= sq_q[SqrtSteps-1].neg;
      den_q   <= {1'b0, sq_q[SqrtSteps-1].root} + {1'b0, cfg_i.stabilizer};
      ph_q    <= cfg_i.step_size * sq_q[SqrtSteps-1].mh[63:32];
      pl_q    <= cfg_i.step_size * sq_q[SqrtSteps-1].mh[31:0];

      q_entry_q.neg  <= p_neg_q;
      q_entry_q.zero <= zero;
      // quotient of 2^32 or more always saturates
      q_entry_q.ovf  <= zero ? (prod != '0) : (prod[87:32] >= {15'd0, dvs});
      q_entry_q.dv   <= dvs;
      q_entry_q.r    <= prod[72:32];
      q_entry_q.a    <= prod[31:0];
    end
  end

  // low 32 quotient bits
  qd_t  qd_in [QSteps];
  qd_t  qd_nx [QSteps];
  qd_t  qd_q  [QSteps];
  logic qd_vi [QSteps];
  logic qd_vq [QSteps];

  for (genvar i = 0; i < QSteps; i++) begin : g_quo
    logic [41:0] t;
    logic        ge;
    if (i == 0) begin : g_first
      assign qd_in[i] = q_entry_q;
      assign qd_vi[i] = q_vq;
    end else begin : g_next
      assign qd_in[i] = qd_q[i-1];
      assign qd_vi[i] = qd_vq[i-1];
    end
    assign t  = {qd_in[i].r, qd_in[i].a[31]};
    assign ge = t >= {1'b0, qd_in[i].dv};
    always_comb begin
      qd_nx[i]   = qd_in[i];
      qd_nx[i].r = ge ? 41'(t - {1'b0, qd_in[i].dv}) : t[40:0];
      qd_nx[i].a = {qd_in[i].a[30:0], ge};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qd_vq[i] <= 1'b0;
      end else if (adv_i) begin
        qd_vq[i] <= qd_vi[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        qd_q[i] <= qd_nx[i];
      end
    end
  end

  // sign and saturation
  qd_t         fin;
  logic [31:0] q;
  logic        sat;

  assign fin = qd_q[QSteps-1];
  assign q   = fin.zero ? 32'd0 : fin.a;

  always_comb begin
    if (fin.neg) begin
      sat      = fin.ovf || (q > 32'h8000_0000);
      update_o = sat ? 32'h8000_0000 : 32'(-q);
    end else begin
      sat      = fin.ovf || q[31];
      update_o = sat ? 32'h7FFF_FFFF : q;
    end
  end

  assign saturated_o = sat;
  assign res_valid_o = qd_vq[QSteps-1];

endmodule

>>> sv/adam_optimizer_update_top.sv
// Throughput: one item per cycle; 64 restoring divide stages, 32 square-root stages and
//   32 final divide stages, each retiring one bit, set the depth. The whole back end
//   advances together and halts only while a finished result is not taken.
// Reset: async active low. Registers return to defaults, powers to one, and a clearing
//   pass zeroes all 1024 entries of the moment store while no input is taken.
module adam_optimizer_update_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [adam_upd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // gradient stream
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [9:0]                     param_index_i,
  input  logic [31:0]                    gradient_i,
  input  logic                           first_of_batch_i,
  // updates
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    update_o,
  output logic                           saturated_o
);
  import adam_upd_pkg::*;

  cfg_t  cfg_q;
  reg_e  reg_sel;
  logic  wr_en;

  logic  adv;
  logic  clearing;
  logic  pop;
  logic  head_valid;
  item_t head;
  mom_t  mom;

  logic        res_valid;
  logic [31:0] res_update;
  logic        res_sat;

  logic        out_valid_q;
  logic [31:0] update_q;
  logic        saturated_q;

  // register file: word address selects the register
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size    <= STEP_SIZE_RST;
      cfg_q.first_decay  <= FIRST_DECAY_RST;
      cfg_q.second_decay <= SECOND_DECAY_RST;
      cfg_q.stabilizer   <= STABILIZER_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_STEP_SIZE:    cfg_q.step_size    <= pwdata[23:0];
        REG_FIRST_DECAY:  cfg_q.first_decay  <= pwdata[15:0];
        REG_SECOND_DECAY: cfg_q.second_decay <= pwdata[15:0];
        REG_STABILIZER:   cfg_q.stabilizer   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STEP_SIZE:    prdata = {8'd0, cfg_q.step_size};
      REG_FIRST_DECAY:  prdata = {16'd0, cfg_q.first_decay};
      REG_SECOND_DECAY: prdata = {16'd0, cfg_q.second_decay};
      REG_STABILIZER:   prdata = cfg_q.stabilizer;
      default:          prdata = '0;
    endcase
  end

  // back end moves whenever the output register is free or being drained
  assign adv = !out_valid_q || out_ready_i;

  // front: takes transfers, advances powers, queues classified items
  adam_upd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .param_index_i    (param_index_i),
    .gradient_i       (gradient_i),
    .first_of_batch_i (first_of_batch_i),
    .cfg_i            (cfg_q),
    .hold_i           (clearing),
    .pop_i            (pop),
    .head_valid_o     (head_valid),
    .head_o           (head)
  );

  // moment read-modify-write with bypass of the item one ahead
  adam_upd_moment u_moment (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .adv_i        (adv),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .mom_o        (mom)
  );

  // bias correction, root, final divide, saturation
  adam_upd_math u_math (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .adv_i       (adv),
    .mom_i       (mom),
    .res_valid_o (res_valid),
    .update_o    (res_update),
    .saturated_o (res_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      update_q    <= res_update;
      saturated_q <= res_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign update_o    = update_q;
  assign saturated_o = saturated_q;

endmodule
